// ===== rtl/core/multi_channel_echo_ranger_unit_macros.svh =====
// assertion macros used by the echo ranger engine
`ifndef MULTI_CHANNEL_ECHO_RANGER_UNIT_MACROS_SVH
`define MULTI_CHANNEL_ECHO_RANGER_UNIT_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define MCER_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// consequent checked in the same cycle as the antecedent
`define MCER_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mcer_pkg.sv =====
// shared types and constants of the echo ranger
package mcer_pkg;

	localparam int SENSOR_COUNT = 4;
	localparam int SENSOR_IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

	localparam int MODULE_W  = 4;
	localparam int COUNTER_W = 16;
	localparam int READING_W = 16;
	localparam int CMD_W     = 2;

	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ECHO = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	localparam logic [READING_W-1:0] NO_READING        = 16'hFFFF;
	localparam logic [COUNTER_W-1:0] FRAME_COMPARE_RST = 16'd62499;
	localparam logic [MODULE_W-1:0]  LAST_MODULE       = MODULE_W'(SENSOR_COUNT - 1);

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 24;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic                echo_level;
		logic [MODULE_W-1:0] module_index;
	} item_t;

	typedef struct packed {
		logic                 trigger_pulse;
		logic [MODULE_W-1:0]  trigger_module;
		logic [READING_W-1:0] read_value;
	} result_t;

endpackage

// ===== rtl/core/multi_channel_echo_ranger_unit.sv =====
// top level of the multi-channel ultrasonic echo ranger
//
// usage
//   slave channel: one beat per command; tuser carries the command (tick,
//   echo edge, read), tdata the echo level and the sensor index of a read.
//   master channel: exactly one result beat per command beat, in order:
//   trigger pulse, sensor now selected for pinging, and the reading (zero
//   unless the command was a read).
//   cfg_wr_en / cfg_wr_data write the frame compare value; write it only
//   while no beat is in flight.
// timing
//   one beat per cycle sustained while m_axis_tready is high; a command beat
//   passes the input register, then the result register. all work for a beat
//   is one pass of counter, subtract and select logic between those registers.
// reset
//   frame counter and echo start go to zero, the sensor select to the last
//   sensor so the first ping goes to sensor 0, every reading to full scale,
//   frame compare to 62499; both channel registers come up empty.
// backpressure
//   while m_axis_tready is low the result register holds its beat, one more
//   command waits in the input register, and s_axis_tready then drops.
module multi_channel_echo_ranger_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// slave side
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [mcer_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // echo_level, module_index[3:0], zero pad
	input  logic [mcer_pkg::CMD_W-1:0]          s_axis_tuser,  // command
	// master side
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [mcer_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // trigger_pulse, trigger_module[3:0], read_value[15:0], zero pad
	// frame compare register
	input  logic                                cfg_wr_en,
	input  logic [mcer_pkg::COUNTER_W-1:0]      cfg_wr_data
);

	// input register stage
	logic              valid_s1;
	mcer_pkg::item_t   item_s1;
	logic              fire_s1;
	logic              out_can_load;
	mcer_pkg::result_t result;

	// a held beat moves on whenever the result register frees up
	assign fire_s1       = valid_s1 && out_can_load;
	assign s_axis_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// payload captured only on an accepted beat, no reset needed
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.command      <= s_axis_tuser;
			item_s1.echo_level   <= s_axis_tdata[0];
			item_s1.module_index <= s_axis_tdata[4:1];
		end
	end

	// ranging state and the per-beat update
	mcer_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fire        (fire_s1),
		.item        (item_s1),
		.result      (result)
	);

	// result register, decoupled from the input side
	mcer_out_stage u_out_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (fire_s1),
		.result        (result),
		.can_load      (out_can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== rtl/core/mcer_engine.sv =====
// ranging state: frame counter, sensor select, echo timing and readings
`include "multi_channel_echo_ranger_unit_macros.svh"

module mcer_engine (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [mcer_pkg::COUNTER_W-1:0]   cfg_wr_data,
	input  logic                             fire,
	input  mcer_pkg::item_t                  item,
	output mcer_pkg::result_t                result
);

	logic [mcer_pkg::COUNTER_W-1:0] frame_compare_q;
	logic [mcer_pkg::COUNTER_W-1:0] frame_counter_q;
	logic [mcer_pkg::MODULE_W-1:0]  current_module_q;
	logic [mcer_pkg::COUNTER_W-1:0] echo_start_q;
	logic [mcer_pkg::READING_W-1:0] readings_q [mcer_pkg::SENSOR_COUNT];

	logic                           wrap;
	logic [mcer_pkg::MODULE_W-1:0]  next_module;
	logic [17:0]                    ticks;
	logic                           saturate;
	logic [mcer_pkg::READING_W-1:0] duration;
	logic                           index_ok;
	logic                           is_tick;
	logic                           is_echo;
	logic                           is_read;

	assign is_tick = (item.command == mcer_pkg::CMD_TICK);
	assign is_echo = (item.command == mcer_pkg::CMD_ECHO);
	assign is_read = (item.command == mcer_pkg::CMD_READ);

	assign wrap = (frame_counter_q >= frame_compare_q);
	assign next_module = (current_module_q == mcer_pkg::LAST_MODULE) ?
		'0 : current_module_q + 1'b1;

	// elapsed ticks, going round the frame period when the stop time is below the start
	always_comb begin
		if (frame_counter_q >= echo_start_q) begin
			ticks = {2'b00, frame_counter_q - echo_start_q};
		end else begin
			ticks = {2'b00, frame_compare_q} + 18'd1 - {2'b00, echo_start_q}
				+ {2'b00, frame_counter_q};
		end
	end

	// negative span (start beyond a lowered period) also lands on full scale
	assign saturate = ticks[17] | (|ticks[16:14]);
	assign duration = saturate ? mcer_pkg::NO_READING : {ticks[13:0], 2'b00};

	assign index_ok = ({1'b0, item.module_index} < 5'(mcer_pkg::SENSOR_COUNT));

	always_comb begin
		result.trigger_pulse  = is_tick & wrap;
		result.trigger_module = (is_tick && wrap) ? next_module : current_module_q;
		result.read_value     = '0;
		if (is_read) begin
			result.read_value = index_ok ?
				readings_q[item.module_index[mcer_pkg::SENSOR_IDX_W-1:0]] :
				mcer_pkg::NO_READING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_compare_q <= mcer_pkg::FRAME_COMPARE_RST;
		end else if (cfg_wr_en) begin
			frame_compare_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_counter_q  <= '0;
			current_module_q <= mcer_pkg::LAST_MODULE;
			echo_start_q     <= '0;
			for (int i = 0; i < mcer_pkg::SENSOR_COUNT; i++) begin
				readings_q[i] <= mcer_pkg::NO_READING;
			end
		end else if (fire) begin
			case (item.command)
				mcer_pkg::CMD_TICK: begin
					if (wrap) begin
						frame_counter_q  <= '0;
						current_module_q <= next_module;
					end else begin
						frame_counter_q <= frame_counter_q + 1'b1;
					end
				end
				mcer_pkg::CMD_ECHO: begin
					if (item.echo_level) begin
						echo_start_q <= frame_counter_q;
					end else begin
						readings_q[current_module_q[mcer_pkg::SENSOR_IDX_W-1:0]] <= duration;
					end
				end
				default: begin
				end
			endcase
		end
	end

	`MCER_ASSERT_NOW(a_module_in_range, 1'b1, {1'b0, current_module_q} < 5'(mcer_pkg::SENSOR_COUNT), "sensor select out of range")
	`MCER_ASSERT_NEXT(a_ping_clears_counter, fire && is_tick && wrap, frame_counter_q == '0 && current_module_q == $past(next_module), "ping did not restart frame")
	`MCER_ASSERT_NEXT(a_counter_only_on_tick, fire && !is_tick, $stable(frame_counter_q) && $stable(current_module_q), "counter moved without a tick")
	`MCER_ASSERT_NOW(a_value_only_on_read, !is_read, result.read_value == '0, "reading shown without a read")

endmodule

// ===== rtl/core/mcer_out_stage.sv =====
// result register toward the master side
module mcer_out_stage (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  mcer_pkg::result_t                   result,
	output logic                                can_load,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [mcer_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

	logic              out_valid_q;
	mcer_pkg::result_t out_result_q;

	assign can_load = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			out_result_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_result_q.read_value,
		out_result_q.trigger_module, out_result_q.trigger_pulse};

endmodule
